>>> rtl/cpu8008_instruction_step_unit_assert.svh
// Assertion macros for the instruction step unit.
`ifndef CPU8008_INSTRUCTION_STEP_UNIT_ASSERT_SVH
`define CPU8008_INSTRUCTION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define C8S_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define C8S_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/c8s_pkg.sv
// ----------------------------------------------------------------------------
// c8s_pkg
// Shared types, codes and helpers of the instruction step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package c8s_pkg;

   localparam logic       REQ_LOAD = 1'b0;
   localparam logic [1:0] STAT_EXEC = 2'd0;
   localparam logic [1:0] STAT_HALT = 2'd1;
   localparam logic [1:0] STAT_LOAD = 2'd2;
   localparam logic [1:0] STAT_LAST = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [13:0] load_addr;
      logic [7:0]  load_data;
      logic        load_last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  step_status;
      logic [13:0] program_counter;
      logic [7:0]  accumulator;
      logic        carry_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        parity_flag;
      logic [7:0]  executed_opcode;
      logic [31:0] tick_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ADDR_PC, ADDR_PC1, ADDR_PC2, ADDR_M, ADDR_LOAD, ADDR_CLEAR
   } addr_sel_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      logic         clear;     // clearing pass write, advance counter
      logic         take;      // capture request
      logic         load_wr;   // write load byte
      logic         cap_op;
      logic         cap_b2;
      logic         cap_b3;
      logic         exec;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_load;
      logic halted;
      logic out_free;
   } status_type;

   // Reduce a value below 2**15 modulo depth (depth >= 256) by shifted
   // compare and subtract.
   function automatic logic [13:0] wrap_addr(logic [14:0] v, int unsigned depth);
      logic [31:0] r;
      logic [31:0] d;
      r = {17'd0, v};
      for (int k = 6; k >= 0; k--) begin
         d = 32'(depth) << k;
         if (r >= d) r = r - d;
      end
      return r[13:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/c8s_ram.sv
// ----------------------------------------------------------------------------
// c8s_ram
// Single-port RAM, registered read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module c8s_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

>>> rtl/c8s_datapath.sv
// ----------------------------------------------------------------------------
// c8s_datapath
// Registers, flags, PC, return stack, memory port, ALU and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module c8s_datapath import c8s_pkg::*; #(
   parameter int MEM_DEPTH   = 16384,
   parameter int STACK_DEPTH = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cmd_type         cmd,
   output status_type           st,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   localparam int AW = $clog2(MEM_DEPTH);

   req_payload_type req_ff;
   logic            skip_ff;
   logic [7:0]      rf_ff [7];
   logic [7:0]      rf_in [7];
   logic [AW-1:0]   pc_ff, pc_in;
   logic [AW-1:0]   stk_ff [STACK_DEPTH];
   logic [AW-1:0]   stk_in [STACK_DEPTH];
   logic            cy_ff, cy_in, z_ff, z_in, s_ff, s_in, p_ff, p_in;
   logic            halt_ff, halt_in;
   logic [31:0]     tick_ff;
   logic [7:0]      op_ff, b2_ff, b3_ff;
   logic [AW-1:0]   clr_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [AW-1:0] maddr, pc1, pc2, nxt, tgt, addr;
   logic [7:0]    rdata, wdata, srcv, aval, res;
   logic [8:0]    sum;
   logic          we, mwe;
   logic [7:0]    low3;
   logic [2:0]    mid;
   logic [1:0]    len;
   logic          cond;

   assign maddr = AW'(wrap_addr({1'b0, rf_ff[5][5:0], rf_ff[6]}, MEM_DEPTH));
   assign pc1   = AW'(wrap_addr(15'(pc_ff) + 15'd1, MEM_DEPTH));
   assign pc2   = AW'(wrap_addr(15'(pc_ff) + 15'd2, MEM_DEPTH));
   assign low3  = op_ff & 8'hC7;
   assign mid   = op_ff[5:3];
   assign len   = (low3 == 8'h44 || low3 == 8'h46) ? 2'd3 :
                  (low3 == 8'h06 || low3 == 8'h04) ? 2'd2 : 2'd1;
   assign nxt   = AW'(wrap_addr(15'(pc_ff) + 15'(len), MEM_DEPTH));
   assign tgt   = AW'(wrap_addr({1'b0, b3_ff[5:0], b2_ff}, MEM_DEPTH));
   assign srcv  = (op_ff[2:0] == 3'd7) ? rdata : rf_ff[op_ff[2:0]];

   always_comb begin
      unique case (mid)
         3'd0: cond = !z_ff;
         3'd1: cond = z_ff;
         3'd2: cond = !cy_ff;
         3'd3: cond = cy_ff;
         3'd4: cond = !p_ff;
         3'd5: cond = p_ff;
         3'd6: cond = !s_ff;
         default: cond = s_ff;
      endcase
   end

   // memory port
   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_PC:    addr = pc_ff;
         ADDR_PC1:   addr = pc1;
         ADDR_PC2:   addr = pc2;
         ADDR_M:     addr = maddr;
         ADDR_LOAD:  addr = req_ff.load_addr[AW-1:0];
         default:    addr = clr_ff;
      endcase
      mwe = cmd.exec && op_ff != 8'hFF && mid == 3'd7 &&
            (op_ff[7:6] == 2'b11 || low3 == 8'h06);
      we  = cmd.clear || mwe ||
            (cmd.load_wr && {1'b0, req_ff.load_addr} < 15'(MEM_DEPTH));
      if (cmd.clear)        wdata = 8'd0;
      else if (cmd.load_wr) wdata = req_ff.load_data;
      else if (low3 == 8'h06) wdata = b2_ff;
      else                  wdata = srcv;
   end

   c8s_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   // instruction execution
   always_comb begin
      for (int i = 0; i < 7; i++) rf_in[i] = rf_ff[i];
      for (int i = 0; i < STACK_DEPTH; i++) stk_in[i] = stk_ff[i];
      pc_in = nxt;
      cy_in = cy_ff; z_in = z_ff; s_in = s_ff; p_in = p_ff;
      halt_in = halt_ff;
      aval = 8'd0;
      res  = 8'd0;
      sum  = 9'd0;
      if (op_ff == 8'hFF) begin
         halt_in = 1'b1;
      end else if (op_ff[7:6] == 2'b11) begin
         if (mid != 3'd7) rf_in[mid] = srcv;
      end else if (low3 == 8'h06) begin
         if (mid != 3'd7) rf_in[mid] = b2_ff;
      end else if (low3 == 8'h00 || low3 == 8'h01) begin
         if (mid != 3'd7) begin
            res = rf_ff[mid] + ((low3 == 8'h00) ? 8'h01 : 8'hFF);
            rf_in[mid] = res;
            z_in = (res == 8'd0); s_in = res[7]; p_in = ~^res;
         end
      end else if (op_ff[7:6] == 2'b10 || low3 == 8'h04) begin
         aval = (op_ff[7:6] == 2'b10) ? srcv : b2_ff;
         case (mid)
            3'd0: begin sum = {1'b0, rf_ff[0]} + {1'b0, aval}; cy_in = sum[8]; end
            3'd1: begin
               sum = {1'b0, rf_ff[0]} + {1'b0, aval} + 9'(cy_ff); cy_in = sum[8];
            end
            3'd3: begin
               sum = {1'b0, rf_ff[0]} - ({1'b0, aval} + 9'(cy_ff)); cy_in = sum[8];
            end
            3'd4: begin sum = {1'b0, rf_ff[0] & aval}; cy_in = 1'b0; end
            3'd5: begin sum = {1'b0, rf_ff[0] ^ aval}; cy_in = 1'b0; end
            3'd6: begin sum = {1'b0, rf_ff[0] | aval}; cy_in = 1'b0; end
            default: begin sum = {1'b0, rf_ff[0]} - {1'b0, aval}; cy_in = sum[8]; end
         endcase
         res = sum[7:0];
         if (mid != 3'd7) rf_in[0] = res;
         z_in = (res == 8'd0); s_in = res[7]; p_in = ~^res;
      end else if (low3 == 8'h02) begin
         case (mid[1:0])
            2'd0: begin rf_in[0] = {rf_ff[0][6:0], rf_ff[0][7]}; cy_in = rf_ff[0][7]; end
            2'd1: begin rf_in[0] = {rf_ff[0][0], rf_ff[0][7:1]}; cy_in = rf_ff[0][0]; end
            2'd2: begin rf_in[0] = {rf_ff[0][6:0], cy_ff}; cy_in = rf_ff[0][7]; end
            default: begin rf_in[0] = {cy_ff, rf_ff[0][7:1]}; cy_in = rf_ff[0][0]; end
         endcase
      end else if (low3 == 8'h44) begin
         if (mid == 3'd0 || cond) pc_in = tgt;
      end else if (low3 == 8'h46 || low3 == 8'h05) begin
         if (low3 == 8'h05 || mid == 3'd0 || cond) begin
            for (int i = STACK_DEPTH - 1; i > 0; i--) stk_in[i] = stk_ff[i-1];
            stk_in[0] = nxt;
            pc_in = (low3 == 8'h05) ? AW'(wrap_addr(15'({mid, 3'd0}), MEM_DEPTH)) : tgt;
         end
      end else if (low3 == 8'h07 || (low3 == 8'h03 && cond)) begin
         pc_in = stk_ff[0];
         for (int i = 0; i < STACK_DEPTH - 1; i++) stk_in[i] = stk_ff[i+1];
         stk_in[STACK_DEPTH-1] = '0;
      end
      if (pc_in == pc_ff) halt_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) rf_ff[i] <= 8'd0;
         for (int i = 0; i < STACK_DEPTH; i++) stk_ff[i] <= '0;
         pc_ff <= '0;
         cy_ff <= 1'b0; z_ff <= 1'b0; s_ff <= 1'b0; p_ff <= 1'b0;
         halt_ff <= 1'b0;
         tick_ff <= 32'd0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.exec) begin
            rf_ff <= rf_in;
            stk_ff <= stk_in;
            pc_ff <= pc_in;
            cy_ff <= cy_in; z_ff <= z_in; s_ff <= s_in; p_ff <= p_in;
            halt_ff <= halt_in;
            tick_ff <= tick_ff + 32'd1;
         end
         if (cmd.out_load)    rsp_valid_ff <= 1'b1;
         else if (rsp_ready)  rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff  <= req_payload;
         skip_ff <= halt_ff;
      end
      if (cmd.cap_op) op_ff <= rdata;
      if (cmd.cap_b2) b2_ff <= rdata;
      if (cmd.cap_b3) b3_ff <= rdata;
      if (cmd.out_load) begin
         rsp_ff.program_counter <= 14'(pc_ff);
         rsp_ff.accumulator     <= rf_ff[0];
         rsp_ff.carry_flag      <= cy_ff;
         rsp_ff.zero_flag       <= z_ff;
         rsp_ff.sign_flag       <= s_ff;
         rsp_ff.parity_flag     <= p_ff;
         rsp_ff.tick_count      <= tick_ff;
         if (req_ff.req_type == REQ_LOAD) begin
            rsp_ff.step_status     <= req_ff.load_last ? STAT_LAST : STAT_LOAD;
            rsp_ff.executed_opcode <= 8'd0;
         end else if (skip_ff) begin
            rsp_ff.step_status     <= STAT_HALT;
            rsp_ff.executed_opcode <= 8'd0;
         end else begin
            rsp_ff.step_status     <= halt_ff ? STAT_HALT : STAT_EXEC;
            rsp_ff.executed_opcode <= op_ff;
         end
      end
   end

   assign st.clear_last  = (clr_ff == AW'(MEM_DEPTH - 1));
   assign st.req_is_load = (req_payload.req_type == REQ_LOAD);
   assign st.halted      = halt_ff;
   assign st.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_payload    = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/c8s_ctrl.sv
// ----------------------------------------------------------------------------
// c8s_ctrl
// Sequencer: clearing pass, load write, fetch and execute steps, result.
// ----------------------------------------------------------------------------
`default_nettype none

module c8s_ctrl import c8s_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type st,
   input  wire logic       req_valid,
   output logic            req_ready,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_OP, S_B2, S_B3, S_M, S_EXEC, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = ADDR_PC;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.addr_sel = ADDR_CLEAR;
            cmd.clear    = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (st.req_is_load) state_in = S_LOAD;
               else if (st.halted) state_in = S_OUT;
               else                state_in = S_OP;
            end
         end
         S_LOAD: begin
            cmd.addr_sel = ADDR_LOAD;
            cmd.load_wr  = 1'b1;
            state_in     = S_OUT;
         end
         S_OP: begin
            cmd.addr_sel = ADDR_PC;
            state_in     = S_B2;
         end
         S_B2: begin
            cmd.addr_sel = ADDR_PC1;
            cmd.cap_op   = 1'b1;
            state_in     = S_B3;
         end
         S_B3: begin
            cmd.addr_sel = ADDR_PC2;
            cmd.cap_b2   = 1'b1;
            state_in     = S_M;
         end
         S_M: begin
            cmd.addr_sel = ADDR_M;
            cmd.cap_b3   = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            cmd.addr_sel = ADDR_M;
            cmd.exec     = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

>>> rtl/cpu8008_instruction_step_unit.sv
// ----------------------------------------------------------------------------
// cpu8008_instruction_step_unit
// 8-bit CPU core that runs one instruction or one memory load per transfer.
// ----------------------------------------------------------------------------
// After reset the unit clears its byte memory, one entry per cycle, until all
// MEM_DEPTH entries are zero; req_ready stays low during that pass. Then each
// request transfer is either a load, which writes one byte, or a step that
// fetches and executes one instruction: the single-port memory is read for
// the opcode, both operand bytes and the M operand in turn, then written for
// an M store. A step while halted goes straight to the result without a
// fetch. One item is in flight at a time; the result register holds a
// finished result until rsp_ready takes it.
`default_nettype none

module cpu8008_instruction_step_unit import c8s_pkg::*; #(
   parameter int MEM_DEPTH   = 16384,
   parameter int STACK_DEPTH = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   cmd_type    cmd;
   status_type st;

   // sequencer
   c8s_ctrl u_ctrl (
      .clock(clock), .reset(reset), .st(st),
      .req_valid(req_valid), .req_ready(req_ready), .cmd(cmd)
   );

   // registers, memory, ALU, result register
   c8s_datapath #(.MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

`include "cpu8008_instruction_step_unit_assert.svh"

   // one item at a time: a transfer makes the unit busy
   `C8S_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "accepted while busy")
   // memory writes never happen while idle
   `C8S_ASSERT_IMP(a_no_idle_write, clock, reset, cmd.load_wr || cmd.exec || cmd.clear, !req_ready, "write while idle")
   // a result is only produced when the result register is free
   `C8S_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, st.out_free, "result overwritten")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the instruction step unit against a cycle-free model of the core.
// A table of loads and steps builds and runs a small program first. Random
// loads and steps follow, most placing an instruction at the live PC to step.
// A final halt closes the run. Every response is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import c8s_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORE_MEM_DEPTH = 16384;
   localparam int RAND_ITEMS     = 320;
   // The memory clear after reset alone runs through all CORE_MEM_DEPTH entries without a transfer.
   localparam int STALL_LIMIT = 4 * CORE_MEM_DEPTH;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   cpu8008_instruction_step_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // -------------------------------------------------------------------------
   // Model of the core. Memory is kept apart from the rest of the state so
   // that a trial step can be run on a saved copy of the registers.
   // -------------------------------------------------------------------------
   typedef struct {
      logic [7:0]  regs [7];
      logic [13:0] pc;
      logic [13:0] stk [8];
      logic        cy, zf, sf, pf;
      logic [31:0] ticks;
      logic        halted;
   } core_state_type;

   core_state_type core;
   logic [7:0]     core_mem [CORE_MEM_DEPTH];

   // Results still owed by the unit, oldest first.
   rsp_payload_type owed_rsp [$];

   int errors    = 0;
   int n_loads   = 0;
   int n_steps   = 0;
   int n_checked = 0;
   bit idle_on   = 1'b1;

   function automatic logic [13:0] m_addr();
      return {core.regs[5][5:0], core.regs[6]};
   endfunction

   function automatic logic [7:0] read_opnd(logic [2:0] idx);
      return (idx == 3'd7) ? core_mem[m_addr()] : core.regs[idx];
   endfunction

   function automatic void write_opnd(logic [2:0] idx, logic [7:0] v, bit mem_wr);
      if (idx != 3'd7) core.regs[idx] = v;
      else if (mem_wr) core_mem[m_addr()] = v;
   endfunction

   function automatic void set_zsp(logic [7:0] r);
      core.zf = (r == 8'd0);
      core.sf = r[7];
      core.pf = ~^r;
   endfunction

   function automatic bit cond_met(logic [2:0] c);
      case (c)
         3'd0: return !core.zf;
         3'd1: return core.zf;
         3'd2: return !core.cy;
         3'd3: return core.cy;
         3'd4: return !core.pf;
         3'd5: return core.pf;
         3'd6: return !core.sf;
         default: return core.sf;
      endcase
   endfunction

   function automatic void push_ret(logic [13:0] a);
      for (int i = 7; i > 0; i--) core.stk[i] = core.stk[i-1];
      core.stk[0] = a;
   endfunction

   function automatic logic [13:0] pop_ret();
      logic [13:0] a;
      a = core.stk[0];
      for (int i = 0; i < 7; i++) core.stk[i] = core.stk[i+1];
      core.stk[7] = '0;
      return a;
   endfunction

   function automatic void alu_op(logic [2:0] kind, logic [7:0] v);
      logic [8:0] a;
      logic [8:0] b;
      logic [8:0] r;
      a = {1'b0, core.regs[0]};
      b = {1'b0, v};
      case (kind)
         3'd0: begin r = a + b;          core.cy = r[8]; end
         3'd1: begin r = a + b + core.cy; core.cy = r[8]; end
         3'd2: begin r = a - b;          core.cy = (a < b); end
         3'd3: begin b = b + core.cy; r = a - b; core.cy = (a < b); end
         3'd4: begin r = a & b; core.cy = 1'b0; end
         3'd5: begin r = a ^ b; core.cy = 1'b0; end
         3'd6: begin r = a | b; core.cy = 1'b0; end
         default: begin
            // compare: flags only, A kept
            r = a - b;
            core.cy = (a < b);
            set_zsp(r[7:0]);
            return;
         end
      endcase
      core.regs[0] = r[7:0];
      set_zsp(r[7:0]);
   endfunction

   function automatic int instr_len(logic [7:0] op);
      logic [7:0] k;
      k = op & 8'hC7;
      if (k == 8'h44 || k == 8'h46) return 3;
      if (k == 8'h06 || k == 8'h04) return 2;
      return 1;
   endfunction

   // Applies one item to the model and returns the response it should cause.
   // With mem_wr clear no memory byte is written (trial runs).
   function automatic rsp_payload_type model_item(req_payload_type r, bit mem_wr);
      rsp_payload_type o;
      logic [7:0]  op, b2, b3, k, a;
      logic [13:0] here, nxt, tgt;
      logic [2:0]  mid;
      o = '0;
      if (r.req_type == REQ_LOAD) begin
         if (mem_wr) core_mem[r.load_addr] = r.load_data;
         o.step_status = r.load_last ? STAT_LAST : STAT_LOAD;
      end else if (core.halted) begin
         o.step_status = STAT_HALT;
      end else begin
         here = core.pc;
         op   = core_mem[here];
         b2   = core_mem[14'(here + 14'd1)];
         b3   = core_mem[14'(here + 14'd2)];
         k    = op & 8'hC7;
         mid  = op[5:3];
         nxt  = 14'(here + 14'(instr_len(op)));
         tgt  = {b3[5:0], b2};
         core.pc = nxt;
         core.ticks++;
         if (op == 8'hFF) begin
            core.halted = 1'b1;
         end else if (op[7:6] == 2'b11) begin
            write_opnd(mid, read_opnd(op[2:0]), mem_wr);
         end else if (k == 8'h06) begin
            write_opnd(mid, b2, mem_wr);
         end else if (k == 8'h00 || k == 8'h01) begin
            // increment / decrement; nothing for M
            if (mid != 3'd7) begin
               core.regs[mid] = core.regs[mid] + ((k == 8'h00) ? 8'h01 : 8'hFF);
               set_zsp(core.regs[mid]);
            end
         end else if (op[7:6] == 2'b10) begin
            alu_op(mid, read_opnd(op[2:0]));
         end else if (k == 8'h04) begin
            alu_op(mid, b2);
         end else if (k == 8'h02) begin
            a = core.regs[0];
            case (mid[1:0])
               2'd0: begin core.regs[0] = {a[6:0], a[7]};    core.cy = a[7]; end
               2'd1: begin core.regs[0] = {a[0], a[7:1]};    core.cy = a[0]; end
               2'd2: begin core.regs[0] = {a[6:0], core.cy}; core.cy = a[7]; end
               default: begin core.regs[0] = {core.cy, a[7:1]}; core.cy = a[0]; end
            endcase
         end else if (k == 8'h44) begin
            if (mid == 3'd0 || cond_met(mid)) core.pc = tgt;
         end else if (k == 8'h46) begin
            if (mid == 3'd0 || cond_met(mid)) begin
               push_ret(nxt);
               core.pc = tgt;
            end
         end else if (k == 8'h07) begin
            core.pc = pop_ret();
         end else if (k == 8'h03) begin
            if (cond_met(mid)) core.pc = pop_ret();
         end else if (k == 8'h05) begin
            push_ret(nxt);
            core.pc = {8'd0, mid, 3'd0};
         end
         // jump onto itself also halts
         if (core.pc == here) core.halted = 1'b1;
         o.step_status     = core.halted ? STAT_HALT : STAT_EXEC;
         o.executed_opcode = op;
      end
      o.program_counter = core.pc;
      o.accumulator     = core.regs[0];
      o.carry_flag      = core.cy;
      o.zero_flag       = core.zf;
      o.sign_flag       = core.sf;
      o.parity_flag     = core.pf;
      o.tick_count      = core.ticks;
      return o;
   endfunction

   // Would a step from the current state halt the core?
   function automatic bit step_would_halt();
      core_state_type saved;
      rsp_payload_type unused;
      bit h;
      saved  = core;
      unused = model_item('{req_type: 1'b1, default: '0}, 1'b0);
      h      = core.halted;
      core   = saved;
      return h;
   endfunction

   // -------------------------------------------------------------------------
   // Clock and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Request side. send_req is entered and left at a rising edge; valid stays
   // high across back-to-back transfers and drops in an idle cycle, for the drain and at the end.
   // -------------------------------------------------------------------------
   task automatic send_req(req_payload_type r, bit lit, rsp_payload_type lit_rsp);
      rsp_payload_type predicted;
      bit got;
      predicted = model_item(r, 1'b1);
      owed_rsp.push_back(lit ? lit_rsp : predicted);
      if (r.req_type == REQ_LOAD) n_loads++;
      else n_steps++;
      while (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do begin
         @(negedge clock);
         got = req_ready;
         @(posedge clock);
      end while (!got);
   endtask

   function automatic req_payload_type load_req(logic [13:0] a, logic [7:0] d, logic last);
      req_payload_type r;
      r.req_type  = REQ_LOAD;
      r.load_addr = a;
      r.load_data = d;
      r.load_last = last;
      return r;
   endfunction

   // Step with random don't-care load fields.
   function automatic req_payload_type step_req();
      req_payload_type r;
      r.req_type  = ~REQ_LOAD;
      r.load_addr = 14'($urandom);
      r.load_data = 8'($urandom);
      r.load_last = 1'($urandom);
      return r;
   endfunction

   typedef struct {
      req_payload_type req;
      bit              lit;
      rsp_payload_type rsp;
   } plan_row_type;

   plan_row_type plan [$];

   function automatic void plan_add(req_payload_type r);
      plan.push_back('{req: r, lit: 1'b0, rsp: '0});
   endfunction

   initial begin
      rsp_payload_type none;
      logic [7:0]  op;
      logic [7:0]  bytes [3];
      logic [7:0]  kept [3];
      logic [13:0] at;
      int len;
      bit ok;

      none = '0;
      for (int i = 0; i < 7; i++) core.regs[i] = '0;
      for (int i = 0; i < 8; i++) core.stk[i] = '0;
      core.pc = '0; core.cy = 0; core.zf = 0; core.sf = 0; core.pf = 0;
      core.ticks = '0; core.halted = 1'b0;
      for (int i = 0; i < CORE_MEM_DEPTH; i++) core_mem[i] = '0;

      // --- directed table ---------------------------------------------------
      // cleared memory: opcode 0x00 is increment A
      plan.push_back('{req: step_req(), lit: 1'b1,
                       rsp: '{STAT_EXEC, 14'd1, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0,
                              8'h00, 32'd1}});
      // top address with block end marker
      plan.push_back('{req: load_req(14'h3FFF, 8'h06, 1'b1), lit: 1'b1,
                       rsp: '{STAT_LAST, 14'd1, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0,
                              8'h00, 32'd1}});
      plan_add(load_req(14'd1, 8'h06, 1'b0));   // MVI A,FF
      plan_add(load_req(14'd2, 8'hFF, 1'b0));
      plan_add(load_req(14'd3, 8'h80, 1'b0));   // ADD A -> carry out
      plan_add(load_req(14'd4, 8'h90, 1'b0));   // SUB A -> zero
      plan_add(load_req(14'd5, 8'h0A, 1'b0));   // RRC
      plan_add(load_req(14'd6, 8'h46, 1'b0));   // CALL 0x20
      plan_add(load_req(14'd7, 8'h20, 1'b0));
      plan_add(load_req(14'd8, 8'hC0, 1'b0));   // upper target bits dropped
      plan_add(load_req(14'h20, 8'h07, 1'b0));  // RET
      plan_add(load_req(14'd9, 8'h44, 1'b0));   // JMP 0x3FFF
      plan_add(load_req(14'd10, 8'hFF, 1'b0));
      plan_add(load_req(14'd11, 8'h3F, 1'b1));
      // MVI at the top address takes its operand from address zero
      for (int i = 0; i < 8; i++) plan_add(step_req());

      foreach (plan[i]) begin
         if (i == 0) @(negedge reset);
         if (i == 0) @(posedge clock);
         send_req(plan[i].req, plan[i].lit, plan[i].rsp);
      end

      // --- random part ------------------------------------------------------
      for (int n = 0; n < RAND_ITEMS; n++) begin
         // long quiet stretch with no idling on either side
         idle_on = !(n >= 100 && n < 200);
         if (n == RAND_ITEMS / 2) begin
            // hold off until the unit has drained
            req_valid <= 1'b0;
            while (owed_rsp.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 80) begin
            // well-formed: place a random instruction at the PC, then step it
            at = core.pc;
            for (int j = 0; j < 3; j++) kept[j] = core_mem[14'(at + 14'(j))];
            ok = 1'b0;
            for (int t = 0; t < 8 && !ok; t++) begin
               op = 8'($urandom_range(254));
               if (t == 7) op = 8'h00;
               bytes[0] = op;
               bytes[1] = 8'($urandom);
               bytes[2] = 8'($urandom);
               len = instr_len(op);
               for (int j = 0; j < len; j++) core_mem[14'(at + 14'(j))] = bytes[j];
               ok = !step_would_halt();
               if (!ok)
                  for (int j = 0; j < 3; j++) core_mem[14'(at + 14'(j))] = kept[j];
            end
            for (int j = 0; j < len; j++)
               send_req(load_req(14'(at + 14'(j)), bytes[j], j == len - 1), 1'b0, none);
            if (ok) send_req(step_req(), 1'b0, none);
         end else if ($urandom_range(1) == 0 || step_would_halt()) begin
            send_req(load_req(14'($urandom), 8'($urandom), 1'($urandom)), 1'b0, none);
         end else begin
            send_req(step_req(), 1'b0, none);
         end
      end

      // --- halt: halting opcode, step while halted, load while halted ------
      idle_on = 1'b1;
      send_req(load_req(core.pc, 8'hFF, 1'b1), 1'b0, none);
      send_req(step_req(), 1'b0, none);
      send_req(step_req(), 1'b0, none);
      send_req(load_req(14'($urandom), 8'($urandom), 1'b0), 1'b0, none);
      send_req(step_req(), 1'b0, none);
      req_valid <= 1'b0;

      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d loads and %0d steps, %0d responses checked, ending halted.",
               n_loads, n_steps, n_checked);
      if (errors == 0 && owed_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d errors, %0d responses outstanding", errors, owed_rsp.size());
         $display("Test completed with failures");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: ready is driven at the rising edge, the transfer is
   // decided from the stable values at the falling edge before it.
   // -------------------------------------------------------------------------
   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      end
   endtask

   initial begin
      rsp_payload_type e;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_ready <= !idle_on || ($urandom_range(99) >= 7);
         @(negedge clock);
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response transfer, expected none, actual 0x%0h",
                        $time, rsp_payload);
            end else begin
               e = owed_rsp.pop_front();
               n_checked++;
               check_field("step_status", e.step_status, rsp_payload.step_status);
               check_field("program_counter", e.program_counter, rsp_payload.program_counter);
               check_field("accumulator", e.accumulator, rsp_payload.accumulator);
               check_field("carry_flag", e.carry_flag, rsp_payload.carry_flag);
               check_field("zero_flag", e.zero_flag, rsp_payload.zero_flag);
               check_field("sign_flag", e.sign_flag, rsp_payload.sign_flag);
               check_field("parity_flag", e.parity_flag, rsp_payload.parity_flag);
               check_field("executed_opcode", e.executed_opcode, rsp_payload.executed_opcode);
               check_field("tick_count", e.tick_count, rsp_payload.tick_count);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: cycles without any transfer on either channel
   // -------------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
